[design/assert_macros.svh]
// Concurrent assertion helpers used by the decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define WDFD_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the standard clock and reset of this block.
`define WDFD_ASSERT(lbl, prop, msg) `WDFD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[design/wdfd_pkg.sv]
package wdfd_pkg;

  localparam int AddrW     = 20;
  localparam int LwW       = 13;
  localparam logic [LwW-1:0] LwReset = 13'd320;

  // Result queue: one byte can produce up to MaxRes words.
  localparam int FifoDepth = 4;
  localparam int MaxRes    = 3;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);
  localparam int NumW      = $clog2(MaxRes + 1);

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_FILL = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [10:0] {
    PH_CNT_LO  = 11'b000_0000_0001,
    PH_CNT_HI  = 11'b000_0000_0010,
    PH_CTL_LO  = 11'b000_0000_0100,
    PH_CTL_HI  = 11'b000_0000_1000,
    PH_PKC_LO  = 11'b000_0001_0000,
    PH_PKC_HI  = 11'b000_0010_0000,
    PH_SKIP    = 11'b000_0100_0000,
    PH_COUNT   = 11'b000_1000_0000,
    PH_COPY    = 11'b001_0000_0000,
    PH_FILL_LO = 11'b010_0000_0000,
    PH_FILL_HI = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] address;
    logic [15:0]      value;
    logic [7:0]       repeat_res;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [NumW-1:0]    n;
    res_t [MaxRes-1:0]  slot;
  } push_t;

endpackage

[design/wdfd_if.sv]
interface wdfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_start;

  modport source (output valid, output data_byte, output chunk_start, input ready);
  modport sink   (input valid, input data_byte, input chunk_start, output ready);
endinterface

interface wdfd_out_if import wdfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [AddrW-1:0] address;
  logic [15:0]      value;
  logic [7:0]       repeat_res;
  logic             last;

  modport source (output valid, output kind, output address, output value,
                  output repeat_res, output last, input ready);
  modport sink   (input valid, input kind, input address, input value,
                  input repeat_res, input last, output ready);
endinterface

[design/wdfd_fifo.sv]
module wdfd_fifo import wdfd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  push_t           push_i,
  input  logic            pop_i,
  output res_t            head_o,
  output logic            valid_o,
  output logic [CntW-1:0] count_o
);

  res_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic [PtrW-1:0] wr_idx [MaxRes];

  always_comb begin
    for (int k = 0; k < MaxRes; k++) begin
      wr_idx[k] = wr_ptr_q + PtrW'(k);
    end
  end

  // Up to MaxRes words are written in one cycle, in order, at consecutive slots.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (NumW'(k) < push_i.n) begin
        mem_q[wr_idx[k]] <= push_i.slot[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop_i);
      count_q  <= count_q + CntW'(push_i.n) - CntW'(pop_i);
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

[design/word_delta_frame_decoder_core.sv]
// Channel   Dir  Payload                                        Handshake
// in_i      in   data_byte[7:0], chunk_start                    valid/ready
// out_o     out  kind[1:0], address[19:0], value[15:0],         valid/ready
//                repeat_res[7:0], last
// cfg       in   cfg_wdata_i[12:0] (line width)                 cfg_we_i
//
// A byte is parsed in the cycle it is accepted; its write words are registered into
// a four-entry result queue that drives out_o.
// One byte per cycle while each byte yields at most one word and out_o keeps up; a byte
// that yields two or three words holds off in_i until the queue drains to one word.
// in_i.ready is high while the result queue holds at most one word.
// After reset the parser ignores bytes until one arrives with chunk_start set.
`include "assert_macros.svh"

module word_delta_frame_decoder_core import wdfd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [LwW-1:0] cfg_wdata_i,
  wdfd_in_if.sink        in_i,
  wdfd_out_if.source     out_o
);

  logic [LwW-1:0]   line_width_q;
  phase_e           phase_q, phase_d;
  logic [7:0]       hold_q, hold_d;
  logic [14:0]      lines_left_q, lines_left_d;
  logic [AddrW-1:0] line_base_q, line_base_d;
  logic [AddrW-1:0] column_q, column_d;
  logic [14:0]      packets_left_q, packets_left_d;
  logic [7:0]       copy_left_q, copy_left_d;
  logic [7:0]       fill_count_q, fill_count_d;
  logic             end_pend_q, end_pend_d;
  logic [7:0]       end_byte_q, end_byte_d;
  logic             finished_q, finished_d;

  logic             in_acc;
  logic [7:0]       b;
  logic [15:0]      w;
  logic [14:0]      skip;
  logic [27:0]      skip_prod;
  logic             do_np;
  logic [MaxRes-1:0] cand_vld;
  res_t             cand [MaxRes];
  logic [NumW-1:0]  idx;
  push_t            push;
  res_t             head;
  logic             fifo_valid;
  logic [CntW-1:0]  fifo_count;

  assign in_acc = in_i.valid && in_i.ready;
  assign b      = in_i.data_byte;
  assign w      = {b, (in_i.chunk_start ? 8'd0 : hold_q)};
  // A line skip word holds 0x10000 minus the number of lines to skip.
  assign skip      = 15'(17'h10000 - 17'(w));
  assign skip_prod = skip * line_width_q;

  always_comb begin
    if (in_i.chunk_start) begin
      phase_d        = PH_CNT_LO;
      finished_d     = 1'b0;
      hold_d         = '0;
      lines_left_d   = '0;
      line_base_d    = '0;
      column_d       = '0;
      packets_left_d = '0;
      copy_left_d    = '0;
      fill_count_d   = '0;
      end_pend_d     = 1'b0;
      end_byte_d     = '0;
    end else begin
      phase_d        = phase_q;
      finished_d     = finished_q;
      hold_d         = hold_q;
      lines_left_d   = lines_left_q;
      line_base_d    = line_base_q;
      column_d       = column_q;
      packets_left_d = packets_left_q;
      copy_left_d    = copy_left_q;
      fill_count_d   = fill_count_q;
      end_pend_d     = end_pend_q;
      end_byte_d     = end_byte_q;
    end

    do_np    = 1'b0;
    cand_vld = '0;
    for (int k = 0; k < MaxRes; k++) begin
      cand[k] = '0;
    end
    cand[0].repeat_res = 8'd1;
    cand[1].kind       = KIND_BYTE;
    cand[1].repeat_res = 8'd1;
    cand[2].kind       = KIND_DONE;

    if (!finished_d) begin
      case (phase_d)
        PH_CNT_LO: begin
          hold_d  = b;
          phase_d = PH_CNT_HI;
        end
        PH_CTL_LO: begin
          hold_d  = b;
          phase_d = PH_CTL_HI;
        end
        PH_PKC_LO: begin
          hold_d  = b;
          phase_d = PH_PKC_HI;
        end
        PH_FILL_LO: begin
          hold_d  = b;
          phase_d = PH_FILL_HI;
        end
        PH_CNT_HI: begin
          if (w[15] || w == 16'd0) begin
            cand_vld[2] = 1'b1;
            finished_d  = 1'b1;
          end else begin
            lines_left_d = w[14:0];
            phase_d      = PH_CTL_LO;
          end
        end
        PH_CTL_HI: begin
          if (w[15]) begin
            if (w[14]) begin
              line_base_d = line_base_d + skip_prod[AddrW-1:0];
              phase_d     = PH_CTL_LO;
            end else begin
              end_byte_d = w[7:0];
              end_pend_d = 1'b1;
              phase_d    = PH_PKC_LO;
            end
          end else begin
            packets_left_d = w[14:0];
            column_d       = '0;
            do_np          = 1'b1;
          end
        end
        PH_PKC_HI: begin
          packets_left_d = w[15] ? 15'd0 : w[14:0];
          column_d       = '0;
          do_np          = 1'b1;
        end
        PH_SKIP: begin
          column_d = column_d + AddrW'(b);
          phase_d  = PH_COUNT;
        end
        PH_COUNT: begin
          if (!b[7]) begin
            copy_left_d = {b[6:0], 1'b0};
            if (b[6:0] == 7'd0) begin
              do_np = 1'b1;
            end else begin
              phase_d = PH_COPY;
            end
          end else begin
            fill_count_d = 8'(9'd256 - 9'(b));
            phase_d      = PH_FILL_LO;
          end
        end
        PH_COPY: begin
          cand_vld[0]     = 1'b1;
          cand[0].kind    = KIND_BYTE;
          cand[0].address = line_base_d + column_d;
          cand[0].value   = {8'd0, b};
          column_d        = column_d + AddrW'(1);
          copy_left_d     = copy_left_d - 8'd1;
          if (copy_left_d == 8'd0) begin
            do_np = 1'b1;
          end
        end
        PH_FILL_HI: begin
          cand_vld[0]        = 1'b1;
          cand[0].kind       = KIND_FILL;
          cand[0].address    = line_base_d + column_d;
          cand[0].value      = w;
          cand[0].repeat_res = fill_count_d;
          column_d           = column_d + AddrW'({fill_count_d, 1'b0});
          do_np              = 1'b1;
        end
        default: begin
          phase_d = PH_CNT_LO;
        end
      endcase

      // Packet finished: start the next one or close the line.
      if (do_np) begin
        if (packets_left_d != 15'd0) begin
          packets_left_d = packets_left_d - 15'd1;
          phase_d        = PH_SKIP;
        end else begin
          if (end_pend_d) begin
            cand_vld[1]     = 1'b1;
            cand[1].address = line_base_d + AddrW'(line_width_q) - AddrW'(1);
            cand[1].value   = {8'd0, end_byte_d};
            end_pend_d      = 1'b0;
          end
          line_base_d  = line_base_d + AddrW'(line_width_q);
          lines_left_d = lines_left_d - 15'd1;
          if (lines_left_d == 15'd0) begin
            cand_vld[2] = 1'b1;
            finished_d  = 1'b1;
          end else begin
            phase_d = PH_CTL_LO;
          end
        end
      end
    end

    // Pack the words in order: data write, last byte write, done.
    push.slot = '0;
    idx       = '0;
    for (int k = 0; k < MaxRes; k++) begin
      if (cand_vld[k]) begin
        push.slot[idx] = cand[k];
        idx            = idx + NumW'(1);
      end
    end
    if (idx != '0) begin
      push.slot[NumW'(idx - NumW'(1))].last = 1'b1;
    end
    push.n = in_acc ? idx : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LwReset;
    end else if (cfg_we_i) begin
      line_width_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_CNT_LO;
      finished_q     <= 1'b1;
      hold_q         <= '0;
      lines_left_q   <= '0;
      line_base_q    <= '0;
      column_q       <= '0;
      packets_left_q <= '0;
      copy_left_q    <= '0;
      fill_count_q   <= '0;
      end_pend_q     <= 1'b0;
      end_byte_q     <= '0;
    end else if (in_acc) begin
      phase_q        <= phase_d;
      finished_q     <= finished_d;
      hold_q         <= hold_d;
      lines_left_q   <= lines_left_d;
      line_base_q    <= line_base_d;
      column_q       <= column_d;
      packets_left_q <= packets_left_d;
      copy_left_q    <= copy_left_d;
      fill_count_q   <= fill_count_d;
      end_pend_q     <= end_pend_d;
      end_byte_q     <= end_byte_d;
    end
  end

  wdfd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.valid && out_o.ready),
    .head_o  (head),
    .valid_o (fifo_valid),
    .count_o (fifo_count)
  );

  // Room for the largest burst one byte can cause.
  assign in_i.ready       = (fifo_count <= CntW'(FifoDepth - MaxRes));
  assign out_o.valid      = fifo_valid;
  assign out_o.kind       = head.kind;
  assign out_o.address    = head.address;
  assign out_o.value      = head.value;
  assign out_o.repeat_res = head.repeat_res;
  assign out_o.last       = head.last;

  `WDFD_ASSERT(a_queue_bound, fifo_count <= CntW'(FifoDepth), "result queue overflow")
  `WDFD_ASSERT(a_start_restarts, in_acc && in_i.chunk_start |=> !finished_q && phase_q == PH_CNT_HI, "chunk start did not restart the parser")
  `WDFD_ASSERT(a_done_is_last, out_o.valid && out_o.kind == KIND_DONE |-> out_o.last, "done word not marked last")
  `WDFD_ASSERT(a_fill_nonzero, out_o.valid && out_o.kind == KIND_FILL |-> out_o.repeat_res != 8'd0, "fill run of zero words")

endmodule

[tb/word_delta_frame_decoder_core_tb.sv]
`timescale 1ns / 100ps

module word_delta_frame_decoder_core_tb;
  import wdfd_pkg::*;

  localparam int ClkHalf    = 6;
  localparam int HoldCycles = 250;
  localparam int PhaseBytes = 50;
  localparam int DirRows    = 32;

  typedef struct {
    logic [7:0]       data;
    logic             start;
    bit               typed;
    int               n;
    kind_e            kind;
    logic [AddrW-1:0] address;
    logic [15:0]      value;
    logic [7:0]       rep;
  } dir_row_t;

  // Rows marked typed carry their write word here; the rest go through the predictor.
  dir_row_t dir_rows [DirRows] = '{
    // Bytes before any chunk start are dropped.
    '{8'h12, 1'b0, 1'b1, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    // Line count zero ends the chunk at once.
    '{8'h00, 1'b1, 1'b1, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h00, 1'b0, 1'b1, 1, KIND_DONE, 20'h0, 16'h0, 8'h0},
    '{8'h55, 1'b0, 1'b1, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    // Negative line count ends the chunk too.
    '{8'hFF, 1'b1, 1'b1, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'hFF, 1'b0, 1'b1, 1, KIND_DONE, 20'h0, 16'h0, 8'h0},
    // One line: last byte word, one copy packet; the final byte gives three words.
    '{8'h01, 1'b1, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h00, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'hAB, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h80, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h01, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h00, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'hFF, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h01, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h00, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'hFF, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    // Largest line skip, a huge packet count, a 128 word fill, then a restart.
    '{8'h03, 1'b1, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h00, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h00, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'hC0, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h00, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h40, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'hF0, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h80, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h34, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h12, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    // Last byte word followed by a negative packet count.
    '{8'h01, 1'b1, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h00, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h00, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'h80, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'hFF, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0},
    '{8'hFF, 1'b0, 1'b0, 0, KIND_BYTE, 20'h0, 16'h0, 8'h0}
  };

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [LwW-1:0] cfg_wdata_i;

  wdfd_in_if  in_ch ();
  wdfd_out_if out_ch ();

  word_delta_frame_decoder_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Predictor state of the parser.
  logic [LwW-1:0]   row_bytes;
  phase_e           parse_ph;
  logic [7:0]       hold_lo;
  logic [15:0]      lines_left;
  logic [AddrW-1:0] line_base;
  logic [AddrW-1:0] column;
  logic [14:0]      packets_left;
  logic [7:0]       copy_left;
  logic [7:0]       fill_cnt;
  logic             end_pending;
  logic [7:0]       end_byte;
  logic             finished;

  res_t       step_out[$];
  res_t       pending_writes[$];
  logic [7:0] frame_bytes[$];

  int errors      = 0;
  int words_seen  = 0;
  int dones_seen  = 0;
  int bytes_sent  = 0;
  int chunks_sent = 0;
  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;
  bit hold_req    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d write words still outstanding", pending_writes.size());
    $display("TB_ERROR");
    $finish;
  end

  function automatic void add_write(kind_e k, logic [AddrW-1:0] a, logic [15:0] v,
                                    logic [7:0] r);
    res_t w;
    w.kind       = k;
    w.address    = a;
    w.value      = v;
    w.repeat_res = r;
    w.last       = 1'b0;
    step_out.push_back(w);
  endfunction

  function automatic void end_line();
    if (end_pending) begin
      add_write(KIND_BYTE, AddrW'(line_base + row_bytes - 1), {8'h00, end_byte}, 8'd1);
      end_pending = 1'b0;
    end
    line_base  = AddrW'(line_base + row_bytes);
    lines_left = lines_left - 16'd1;
    if (lines_left == 16'd0) begin
      add_write(KIND_DONE, '0, 16'h0, 8'h0);
      finished = 1'b1;
    end else begin
      parse_ph = PH_CTL_LO;
    end
  endfunction

  function automatic void next_packet();
    if (packets_left != 15'd0) begin
      packets_left = packets_left - 15'd1;
      parse_ph     = PH_SKIP;
    end else begin
      end_line();
    end
  endfunction

  // Advances the parser by one byte and leaves its write words in step_out.
  function automatic void decode_byte(logic [7:0] b, logic s);
    logic [15:0] w;
    logic [63:0] skip;
    step_out.delete();
    w = {b, hold_lo};
    if (s) begin
      parse_ph     = PH_CNT_LO;
      finished     = 1'b0;
      lines_left   = '0;
      line_base    = '0;
      column       = '0;
      packets_left = '0;
      copy_left    = '0;
      fill_cnt     = '0;
      end_pending  = 1'b0;
      end_byte     = '0;
      hold_lo      = '0;
    end
    if (finished) return;
    case (parse_ph)
      PH_CNT_LO: begin
        hold_lo  = b;
        parse_ph = PH_CNT_HI;
      end
      PH_CTL_LO: begin
        hold_lo  = b;
        parse_ph = PH_CTL_HI;
      end
      PH_PKC_LO: begin
        hold_lo  = b;
        parse_ph = PH_PKC_HI;
      end
      PH_FILL_LO: begin
        hold_lo  = b;
        parse_ph = PH_FILL_HI;
      end
      PH_CNT_HI: begin
        if (w[15] || w == 16'h0) begin
          add_write(KIND_DONE, '0, 16'h0, 8'h0);
          finished = 1'b1;
        end else begin
          lines_left = w;
          parse_ph   = PH_CTL_LO;
        end
      end
      PH_CTL_HI: begin
        if (w[15]) begin
          if (w[14]) begin
            skip      = 64'h10000 - w;
            line_base = AddrW'(line_base + skip * row_bytes);
            parse_ph  = PH_CTL_LO;
          end else begin
            end_byte    = w[7:0];
            end_pending = 1'b1;
            parse_ph    = PH_PKC_LO;
          end
        end else begin
          packets_left = w[14:0];
          column       = '0;
          next_packet();
        end
      end
      PH_PKC_HI: begin
        packets_left = w[15] ? 15'd0 : w[14:0];
        column       = '0;
        next_packet();
      end
      PH_SKIP: begin
        column   = column + b;
        parse_ph = PH_COUNT;
      end
      PH_COUNT: begin
        if (!b[7]) begin
          copy_left = {b[6:0], 1'b0};
          if (copy_left == 8'd0) next_packet();
          else parse_ph = PH_COPY;
        end else begin
          fill_cnt = 8'(9'd256 - b);
          parse_ph = PH_FILL_LO;
        end
      end
      PH_COPY: begin
        add_write(KIND_BYTE, line_base + column, {8'h00, b}, 8'd1);
        column    = column + AddrW'(1);
        copy_left = copy_left - 8'd1;
        if (copy_left == 8'd0) next_packet();
      end
      PH_FILL_HI: begin
        add_write(KIND_FILL, line_base + column, w, fill_cnt);
        column = AddrW'(column + 2 * fill_cnt);
        next_packet();
      end
      default: ;
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  function automatic void put_word(logic [15:0] w);
    frame_bytes.push_back(w[7:0]);
    frame_bytes.push_back(w[15:8]);
  endfunction

  // Builds a well-formed chunk with random content; now and then an odd line count
  // or a packet count too large to finish, which the next chunk start cuts off.
  function automatic void build_chunk();
    int lines;
    int pk;
    int n;
    int sel;
    int skip;
    bit has_end;
    frame_bytes.delete();
    lines = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
    sel   = $urandom_range(0, 19);
    if (sel == 0) put_word(16'h0000);
    else if (sel == 1) put_word({1'b1, 15'($urandom)});
    else put_word(16'(lines));
    for (int l = 0; l < lines; l++) begin
      if ($urandom_range(0, 4) == 0) begin
        skip = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16'h4000)
                                           : $urandom_range(1, 4);
        put_word(16'(17'h10000 - skip));
      end
      has_end = ($urandom_range(0, 2) == 0);
      if (has_end) put_word({2'b10, 6'($urandom), 8'($urandom)});
      if (has_end && $urandom_range(0, 3) == 0) begin
        put_word({1'b1, 15'($urandom)});
        pk = 0;
      end else if ($urandom_range(0, 39) == 0) begin
        put_word({2'b01, 14'($urandom)});
        pk = 3;
      end else begin
        pk = $urandom_range(0, 3);
        put_word(16'(pk));
      end
      for (int p = 0; p < pk; p++) begin
        frame_bytes.push_back(8'($urandom));
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          frame_bytes.push_back(8'h00);
        end else if (sel <= 5) begin
          n = ($urandom_range(0, 29) == 0) ? $urandom_range(64, 127) : $urandom_range(1, 3);
          frame_bytes.push_back(8'(n));
          repeat (2 * n) frame_bytes.push_back(8'($urandom));
        end else begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 128) : $urandom_range(1, 4);
          frame_bytes.push_back(8'(256 - n));
          put_word(16'($urandom));
        end
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s, input bit use_predictor);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.chunk_start <= s;
    do @(posedge clk_i); while (!in_ch.ready);
    if (s) chunks_sent++;
    decode_byte(b, s);
    if (use_predictor) begin
      foreach (step_out[j]) pending_writes.push_back(step_out[j]);
    end
  endtask

  // The write words may trail the last byte through the result queue.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_line_width(input logic [LwW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    row_bytes = v;
  endtask

  // Receiver side: random stall bursts, plus one long hold on request.
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.kind       = kind_e'(out_ch.kind);
      got.address    = out_ch.address;
      got.value      = out_ch.value;
      got.repeat_res = out_ch.repeat_res;
      got.last       = out_ch.last;
      words_seen++;
      if (got.kind == KIND_DONE) dones_seen++;
      if (pending_writes.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected write word kind %0d addr %05h value %04h repeat %0d",
                   $time, got.kind, got.address, got.value, got.repeat_res);
      end else begin
        want = pending_writes.pop_front();
        if (got.kind !== want.kind || got.address !== want.address ||
            got.value !== want.value || got.repeat_res !== want.repeat_res ||
            got.last !== want.last) begin
          errors++;
          if (errors <= 40) begin
            $write("%0t: expected kind %0d addr %05h value %04h repeat %0d last %0b, ",
                   $time, want.kind, want.address, want.value, want.repeat_res,
                   want.last);
            $display("got kind %0d addr %05h value %04h repeat %0d last %0b",
                     got.kind, got.address, got.value, got.repeat_res, got.last);
          end
        end
      end
    end
  end

  initial begin
    logic [LwW-1:0] widths [5];
    int  len;
    int  phase_bytes;
    bit  hold_done;
    bit  pause_done;
    res_t typed_word;

    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= '0;
    in_ch.chunk_start <= 1'b0;

    row_bytes    = LwReset;
    parse_ph     = PH_CNT_LO;
    hold_lo      = '0;
    lines_left   = '0;
    line_base    = '0;
    column       = '0;
    packets_left = '0;
    copy_left    = '0;
    fill_cnt     = '0;
    end_pending  = 1'b0;
    end_byte     = '0;
    finished     = 1'b1;

    widths     = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'($urandom_range(2, 4095))};
    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part runs at the reset line width.
    for (int i = 0; i < DirRows; i++) begin
      send_byte(dir_rows[i].data, dir_rows[i].start, !dir_rows[i].typed);
      if (dir_rows[i].typed && dir_rows[i].n == 1) begin
        typed_word.kind       = dir_rows[i].kind;
        typed_word.address    = dir_rows[i].address;
        typed_word.value      = dir_rows[i].value;
        typed_word.repeat_res = dir_rows[i].rep;
        typed_word.last       = 1'b1;
        pending_writes.push_back(typed_word);
      end
    end
    bytes_sent += DirRows;

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      set_line_width(widths[p]);
      if (p == 4) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        // The long hold starts with the phase so that the whole phase pushes against it.
        if (p == 1 && !hold_done) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if (p == 2 && !pause_done && phase_bytes > 30) begin
          wait_idle();
          pause_done = 1'b1;
        end
        build_chunk();
        len = frame_bytes.size();
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
        for (int k = 0; k < len; k++) send_byte(frame_bytes[k], k == 0, 1'b1);
        phase_bytes += len;
        bytes_sent  += len;
        // Stray bytes after a chunk, now and then with a chunk start among them.
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3))
            send_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b1);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d chunk bytes in %0d chunk starts over line widths 320, 1, 4096, 0, 8191",
             bytes_sent, chunks_sent);
    $display("and one random width; %0d write words checked, %0d done markers, %0d mismatches.",
             words_seen, dones_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
